// ----- src/tlb_pkg.sv -----
`default_nettype none

package tlb_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PID_W           = 8;
    localparam int PAGE_W          = 20;
    localparam int OFFSET_W        = 12;
    localparam int VA_W            = PAGE_W + OFFSET_W;
    localparam int IN_TDATA_W      = 80;
    localparam int OUT_TDATA_W     = 32;

    typedef enum logic [0:0] {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } kind_t;

    // Search token walking down the row of entry cells.
    // For a lookup, found marks a match and frame picks up the entry's frame.
    // For an insert, found marks an empty entry and frame carries the new frame;
    // seen marks that at least one valid entry has been compared for age.
    typedef struct packed {
        logic              active;
        kind_t             kind;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        logic [OFFSET_W-1:0] offset;
        logic [PAGE_W-1:0] frame;
        logic              found;
        logic              seen;
    } tlb_tok_t;

    // Update broadcast to every cell once the token has left the row.
    typedef struct packed {
        logic              en;
        logic              write;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] frame;
    } tlb_upd_t;

endpackage

`default_nettype wire

// ----- src/tlb_cell.sv -----
`default_nettype none

module tlb_cell
    import tlb_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int CELL_IDX    = 0,
    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1,
    localparam int LW = IW + 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tlb_tok_t      tok_in,
    input  wire logic [IW-1:0] idx_in,
    input  wire logic [IW-1:0] rank_in,
    output tlb_tok_t           tok_out,
    output logic [IW-1:0]      idx_out,
    output logic [IW-1:0]      rank_out,
    input  wire tlb_upd_t      upd,
    input  wire logic [IW-1:0] upd_idx,
    input  wire logic [LW-1:0] upd_limit
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic              valid_reg, valid_next;
    logic [IW-1:0]     rank_reg,  rank_next;
    logic [PID_W-1:0]  pid_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] frame_reg;

    tlb_tok_t      tok_reg,  tok_next;
    logic [IW-1:0] idx_reg,  idx_next;
    logic [IW-1:0] rnk_reg,  rnk_next;

    logic hit_here;
    logic mine;

    // Search step for this entry
    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        rnk_next = rank_in;
        hit_here = valid_reg && (pid_reg == tok_in.pid) && (page_reg == tok_in.page);
        if (tok_in.active && !tok_in.found)
        begin
            unique case (tok_in.kind)
                KIND_LOOKUP:
                begin
                    if (hit_here)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.frame = frame_reg;
                        idx_next       = MY_IDX;
                        rnk_next       = rank_reg;
                    end
                end
                KIND_INSERT:
                begin
                    if (!valid_reg)
                    begin
                        tok_next.found = 1'b1;
                        idx_next       = MY_IDX;
                    end
                    else if (!tok_in.seen || (rank_reg > rank_in))
                    begin
                        tok_next.seen = 1'b1;
                        idx_next      = MY_IDX;
                        rnk_next      = rank_reg;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Recency update
    always_comb
    begin
        mine       = (upd_idx == MY_IDX);
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (mine)
            begin
                rank_next = '0;
                if (upd.write)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && ({1'b0, rank_reg} < upd_limit))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rnk_reg        <= rnk_next;
        if (upd.en && upd.write && mine)
        begin
            pid_reg   <= upd.pid;
            page_reg  <= upd.page;
            frame_reg <= upd.frame;
        end
    end

    assign tok_out  = tok_reg;
    assign idx_out  = idx_reg;
    assign rank_out = rnk_reg;

endmodule

`default_nettype wire

// ----- src/tlb_lru_lookup_insert.sv -----
// Fully associative TLB, 4 KB pages, least-recently-used replacement.
// Input stream (s_axis_*): one transfer is one item. tuser[0] selects lookup (0)
// or insert (1); tdata carries pid, virtual address, page number and frame.
// Output stream (m_axis_*): exactly one transfer per item. tuser[0] is hit,
// tdata the physical address (frame << 12 | offset), zero on miss or insert.
// Each entry sits in its own cell; the cells form a row and a search token
// steps one cell per cycle through the cell registers, then waits in the end
// register until the output can take it, and its result is then registered
// in the output register. The row holds one item at a time: the input
// reopens when the result is registered, so a new item is taken only after
// the last one is finished.
// The recency ranks and the written entry are updated in the same cycle the
// result is registered.
// Reset empties every entry and drops any item in flight.
// A stalled output holds its result; a finished search then waits in the end
// register, and the input stays closed until that search is committed.
`default_nettype none

module tlb_lru_lookup_insert
    import tlb_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] pid, [39:8] virtual_address, [59:40] page_number, [79:60] frame_number
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] physical_address
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] hit
    output logic [0:0]                  m_axis_tuser
);

    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] ALL_LIMIT = LW'(TLB_ENTRIES);

    tlb_tok_t      tok_w  [0:TLB_ENTRIES];
    logic [IW-1:0] idx_w  [0:TLB_ENTRIES];
    logic [IW-1:0] rank_w [0:TLB_ENTRIES];

    logic busy_reg, busy_next;
    logic fin_valid_reg, fin_valid_next;
    tlb_tok_t      fin_tok_reg;
    logic [IW-1:0] fin_idx_reg;
    logic [IW-1:0] fin_rank_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg,   out_hit_next;
    logic [OUT_TDATA_W-1:0] out_pa_reg,    out_pa_next;

    logic          in_xfer;
    logic          commit;
    tlb_upd_t      upd;
    logic [IW-1:0] upd_idx;
    logic [LW-1:0] upd_limit;
    logic          hit;

    assign s_axis_tready = !busy_reg;
    assign in_xfer       = s_axis_tvalid && !busy_reg;

    always_comb
    begin
        tok_w[0].active = in_xfer;
        tok_w[0].kind   = kind_t'(s_axis_tuser[0]);
        tok_w[0].pid    = s_axis_tdata[7:0];
        tok_w[0].offset = s_axis_tdata[19:8];
        tok_w[0].frame  = s_axis_tdata[79:60];
        tok_w[0].found  = 1'b0;
        tok_w[0].seen   = 1'b0;
        if (kind_t'(s_axis_tuser[0]) == KIND_INSERT)
        begin
            tok_w[0].page = s_axis_tdata[59:40];
        end
        else
        begin
            tok_w[0].page = s_axis_tdata[39:20];
        end
        idx_w[0]  = '0;
        rank_w[0] = '0;
    end

    for (genvar g = 0; g < TLB_ENTRIES; g++)
    begin : g_cell
        tlb_cell #(
            .TLB_ENTRIES (TLB_ENTRIES),
            .CELL_IDX    (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok_w[g]),
            .idx_in    (idx_w[g]),
            .rank_in   (rank_w[g]),
            .tok_out   (tok_w[g+1]),
            .idx_out   (idx_w[g+1]),
            .rank_out  (rank_w[g+1]),
            .upd       (upd),
            .upd_idx   (upd_idx),
            .upd_limit (upd_limit)
        );
    end

    // Commit: result out, entries updated
    always_comb
    begin
        commit         = fin_valid_reg && (!out_valid_reg || m_axis_tready);
        hit            = (fin_tok_reg.kind == KIND_LOOKUP) && fin_tok_reg.found;
        upd.pid        = fin_tok_reg.pid;
        upd.page       = fin_tok_reg.page;
        upd.frame      = fin_tok_reg.frame;
        upd.write      = (fin_tok_reg.kind == KIND_INSERT);
        upd.en         = commit && (upd.write || fin_tok_reg.found);
        upd_idx        = fin_idx_reg;
        if (upd.write && fin_tok_reg.found)
        begin
            upd_limit = ALL_LIMIT;
        end
        else
        begin
            upd_limit = {1'b0, fin_rank_reg};
        end

        fin_valid_next = fin_valid_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_pa_next    = out_pa_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            busy_next = 1'b1;
        end
        if (tok_w[TLB_ENTRIES].active)
        begin
            fin_valid_next = 1'b1;
        end
        if (commit)
        begin
            fin_valid_next = 1'b0;
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_hit_next   = hit;
            out_pa_next    = hit ? {fin_tok_reg.frame, fin_tok_reg.offset} : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_w[TLB_ENTRIES].active)
        begin
            fin_tok_reg  <= tok_w[TLB_ENTRIES];
            fin_idx_reg  <= idx_w[TLB_ENTRIES];
            fin_rank_reg <= rank_w[TLB_ENTRIES];
        end
        out_hit_reg <= out_hit_next;
        out_pa_reg  <= out_pa_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_pa_reg;
    assign m_axis_tuser[0] = out_hit_reg;

endmodule

`default_nettype wire

// ----- src/tlb_chk.sv -----
`default_nettype none

module tlb_chk
    import tlb_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]             m_axis_tuser
);

    // A result waiting on the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer withdrawn while stalled");

    // Misses and inserts report a zero address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("non-zero address without hit");

    // One item in flight: the input closes after each transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while search busy");

    // A result never shows up on the cycle right after an input transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind tlb_lru_lookup_insert tlb_chk u_tlb_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
